FILE: rtl/core/tshbl_pkg.sv
package tshbl_pkg;

    // Field widths fixed by the frame and register formats
    localparam int FLIP_W       = 8;
    localparam int ID_W         = 29;
    localparam int BYTE_W       = 8;
    localparam int LAMP_W       = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 29;
    localparam int COUNT_BITS_DEF = 8;

    // Register reset values
    localparam logic [FLIP_W-1:0] FLIP_COUNT_RST      = 8'd50;
    localparam logic [ID_W-1:0]   STEERING_MSG_ID_RST = '0;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FLIP_COUNT      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEERING_MSG_ID = 1'd1;

    // Request bits in the first byte of the steering frame
    localparam int REQ_RIGHT_BIT = 0;
    localparam int REQ_LEFT_BIT  = 1;

    // Lamp bit positions: front left, front right, rear left, rear right
    localparam logic [LAMP_W-1:0] LAMP_FL = 4'b0001;
    localparam logic [LAMP_W-1:0] LAMP_FR = 4'b0010;
    localparam logic [LAMP_W-1:0] LAMP_RL = 4'b0100;
    localparam logic [LAMP_W-1:0] LAMP_RR = 4'b1000;

    localparam logic [LAMP_W-1:0] OWN_HAZARD = LAMP_FL | LAMP_FR | LAMP_RL | LAMP_RR;
    localparam logic [LAMP_W-1:0] OWN_LEFT   = LAMP_FL | LAMP_RL;
    localparam logic [LAMP_W-1:0] OWN_RIGHT  = LAMP_FR | LAMP_RR;

    // Input beat kinds
    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_FRAME = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HAZARD = 3'd1,
        MODE_LEFT   = 3'd2,
        MODE_RIGHT  = 3'd3,
        MODE_BRAKE  = 3'd4
    } mode_t;

    typedef struct packed {
        logic              action;
        logic              brake;
        logic              hazard;
        logic [ID_W-1:0]   frame_id;
        logic [BYTE_W-1:0] frame_byte;
    } cmd_t;

    typedef struct packed {
        logic [FLIP_W-1:0] flip_count;
        logic [ID_W-1:0]   steering_msg_id;
    } cfg_t;

endpackage

FILE: rtl/core/tshbl_if.sv
interface tshbl_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic                          brake;
    logic                          hazard;
    logic [tshbl_pkg::ID_W-1:0]    frame_id;
    logic [tshbl_pkg::BYTE_W-1:0]  frame_byte;

    modport source (output valid, action, brake, hazard, frame_id, frame_byte, input ready);
    modport sink   (input valid, action, brake, hazard, frame_id, frame_byte, output ready);
endinterface

interface tshbl_lamp_if;
    logic valid;
    logic ready;
    logic front_left;
    logic front_right;
    logic rear_left;
    logic rear_right;
    logic brake_out;

    modport source (output valid, front_left, front_right, rear_left, rear_right, brake_out,
                    input ready);
    modport sink   (input valid, front_left, front_right, rear_left, rear_right, brake_out,
                    output ready);
endinterface

FILE: rtl/core/turn_signal_hazard_brake_lamps.sv
// Turn signal, hazard and brake lamp controller.
// cmd channel: one beat per timer tick (action 0, with brake and hazard
// switch levels) or per received CAN frame (action 1, with id and first
// data byte). A frame whose id matches steering_msg_id sets the turn request.
// lamp channel: one beat per tick with the four lamp drives and brake_out;
// frames give no beat.
// Config port: cfg_we, cfg_index 0 (flip_count) or 1 (steering_msg_id); the user
// must write only while no beat is in flight. The block does not enforce this.
// A beat accepted into the input register is processed from there, and a
// tick's result is written to the result register. Throughput is one beat
// per cycle while the receiver does not stall ticks, set by the single input
// register feeding the state update and the result register.
// When the receiver stalls, the held result keeps its value; a frame beat
// can still go through, and a tick waits in the input register, after which
// cmd.ready drops.
// Reset clears turn requests, mode (idle), tick counter and lamps, and loads
// flip_count = 50 and steering_msg_id = 0.
module turn_signal_hazard_brake_lamps #(
    parameter int COUNT_BITS = tshbl_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tshbl_cmd_if.sink                          cmd,
    tshbl_lamp_if.source                       lamp,
    input  logic                               cfg_we,
    input  logic [tshbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tshbl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    tshbl_pkg::cfg_t               cfg;
    tshbl_pkg::cmd_t               cmd_reg;
    logic                          cmd_valid_reg;
    logic                          res_valid_reg;
    logic [tshbl_pkg::LAMP_W-1:0]  res_lamp_reg;
    logic                          res_brake_reg;
    logic [tshbl_pkg::LAMP_W-1:0]  lamp_next;
    tshbl_pkg::mode_t              mode;
    logic                          is_tick;
    logic                          step;

    tshbl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Held beat moves on when it is a frame or the result slot frees up
    assign is_tick   = cmd_reg.action == tshbl_pkg::ACTION_TICK;
    assign step      = cmd_valid_reg && (!is_tick || !res_valid_reg || lamp.ready);
    assign cmd.ready = !cmd_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd.ready)
            cmd_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_reg.action     <= cmd.action;
            cmd_reg.brake      <= cmd.brake;
            cmd_reg.hazard     <= cmd.hazard;
            cmd_reg.frame_id   <= cmd.frame_id;
            cmd_reg.frame_byte <= cmd.frame_byte;
        end
    end

    tshbl_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cmd       (cmd_reg),
        .cfg       (cfg),
        .lamp_next (lamp_next),
        .mode      (mode)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step && is_tick)
            res_valid_reg <= 1'b1;
        else if (lamp.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && is_tick)
        begin
            res_lamp_reg  <= lamp_next;
            res_brake_reg <= cmd_reg.brake;
        end
    end

    assign lamp.valid       = res_valid_reg;
    assign lamp.front_left  = |(res_lamp_reg & tshbl_pkg::LAMP_FL);
    assign lamp.front_right = |(res_lamp_reg & tshbl_pkg::LAMP_FR);
    assign lamp.rear_left   = |(res_lamp_reg & tshbl_pkg::LAMP_RL);
    assign lamp.rear_right  = |(res_lamp_reg & tshbl_pkg::LAMP_RR);
    assign lamp.brake_out   = res_brake_reg;

    // A processed tick always leaves a result behind
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_tick |=> res_valid_reg)
        else $error("tick processed without a result");

    // Both front lamps lit only while hazard flashing
    a_front_pair_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && lamp.front_left && lamp.front_right
        |-> mode == tshbl_pkg::MODE_HAZARD)
        else $error("both front lamps lit outside hazard mode");

    // Empty input register never blocks the sender
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid_reg |-> cmd.ready)
        else $error("input stalled with empty input register");

endmodule

FILE: rtl/core/tshbl_cfg.sv
module tshbl_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tshbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tshbl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output tshbl_pkg::cfg_t                    cfg
);

    logic [tshbl_pkg::FLIP_W-1:0] flip_count_reg;
    logic [tshbl_pkg::ID_W-1:0]   steering_msg_id_reg;

    // Register writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_count_reg      <= tshbl_pkg::FLIP_COUNT_RST;
            steering_msg_id_reg <= tshbl_pkg::STEERING_MSG_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tshbl_pkg::REG_FLIP_COUNT:
                    flip_count_reg <= cfg_wdata[tshbl_pkg::FLIP_W-1:0];
                tshbl_pkg::REG_STEERING_MSG_ID:
                    steering_msg_id_reg <= cfg_wdata[tshbl_pkg::ID_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg.flip_count      = flip_count_reg;
    assign cfg.steering_msg_id = steering_msg_id_reg;

endmodule

FILE: rtl/core/tshbl_ctrl.sv
module tshbl_ctrl #(
    parameter int COUNT_BITS = tshbl_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  tshbl_pkg::cmd_t                cmd,
    input  tshbl_pkg::cfg_t                cfg,
    output logic [tshbl_pkg::LAMP_W-1:0]   lamp_next,
    output tshbl_pkg::mode_t               mode
);

    // Compare width covers both the counter and the flip count
    localparam int CMP_W = (COUNT_BITS > tshbl_pkg::FLIP_W) ? COUNT_BITS : tshbl_pkg::FLIP_W;

    logic                          left_req_reg,  left_req_next;
    logic                          right_req_reg, right_req_next;
    tshbl_pkg::mode_t              mode_reg,      mode_next;
    logic [COUNT_BITS-1:0]         count_reg,     count_next;
    logic [tshbl_pkg::LAMP_W-1:0]  lamp_reg;

    logic                          flashing;
    tshbl_pkg::mode_t              flash_mode;
    logic [tshbl_pkg::LAMP_W-1:0]  own;
    logic [tshbl_pkg::LAMP_W-1:0]  lamp_entry;
    logic [COUNT_BITS-1:0]         count_entry;
    logic [COUNT_BITS-1:0]         count_inc;
    logic                          flip;

    // Steering frame: update turn requests when the id matches
    always_comb
    begin
        left_req_next  = left_req_reg;
        right_req_next = right_req_reg;
        if (cmd.action == tshbl_pkg::ACTION_FRAME && cmd.frame_id == cfg.steering_msg_id)
        begin
            left_req_next  = cmd.frame_byte[tshbl_pkg::REQ_LEFT_BIT];
            right_req_next = !cmd.frame_byte[tshbl_pkg::REQ_LEFT_BIT]
                             && cmd.frame_byte[tshbl_pkg::REQ_RIGHT_BIT];
        end
    end

    // Mode priority for a tick: hazard, left, right
    always_comb
    begin
        flashing   = 1'b1;
        flash_mode = tshbl_pkg::MODE_HAZARD;
        own        = tshbl_pkg::OWN_HAZARD;
        if (cmd.hazard)
        begin
            flash_mode = tshbl_pkg::MODE_HAZARD;
            own        = tshbl_pkg::OWN_HAZARD;
        end
        else if (left_req_reg)
        begin
            flash_mode = tshbl_pkg::MODE_LEFT;
            own        = tshbl_pkg::OWN_LEFT;
        end
        else if (right_req_reg)
        begin
            flash_mode = tshbl_pkg::MODE_RIGHT;
            own        = tshbl_pkg::OWN_RIGHT;
        end
        else
        begin
            flashing = 1'b0;
        end
    end

    // Flash step: restart on mode entry, count, toggle at the flip count
    always_comb
    begin
        count_entry = (mode_reg != flash_mode) ? '0 : count_reg;
        lamp_entry  = (mode_reg != flash_mode) ? (lamp_reg & ~own) : lamp_reg;
        count_inc   = count_entry + 1'b1;
        flip        = CMP_W'(count_inc) >= CMP_W'(cfg.flip_count);
    end

    // Next state and lamps for a tick
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        lamp_next  = lamp_reg;
        if (cmd.action == tshbl_pkg::ACTION_TICK)
        begin
            if (flashing)
            begin
                mode_next  = flash_mode;
                count_next = flip ? '0 : count_inc;
                lamp_next  = (flip ? (lamp_entry ^ own) : lamp_entry) & own;
            end
            else if (cmd.brake)
            begin
                mode_next = tshbl_pkg::MODE_BRAKE;
                lamp_next = tshbl_pkg::LAMP_RL | tshbl_pkg::LAMP_RR;
            end
            else
            begin
                mode_next = tshbl_pkg::MODE_IDLE;
                lamp_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_req_reg  <= 1'b0;
            right_req_reg <= 1'b0;
            mode_reg      <= tshbl_pkg::MODE_IDLE;
            count_reg     <= '0;
            lamp_reg      <= '0;
        end
        else if (step)
        begin
            left_req_reg  <= left_req_next;
            right_req_reg <= right_req_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            lamp_reg      <= lamp_next;
        end
    end

    assign mode = mode_reg;

endmodule
